// ===== rtl/tlvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvp_pkg: shared types for the TLV record parser
// Byte item, result item, parser phase, byte kinds and the parser state record.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvp_pkg;

  localparam logic [7:0] EXT_MARKER = 8'hFF;

  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_LEN   = 3'd1,
    PH_EXTHI = 3'd2,
    PH_EXTLO = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TAG   = 3'd0,
    KIND_LEN   = 3'd1,
    KIND_EXTHI = 3'd2,
    KIND_EXTLO = 3'd3,
    KIND_DATA  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       payload_last;
  } item_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [2:0]  byte_kind;
    logic [7:0]  record_tag;
    logic [15:0] record_length;
    logic [15:0] data_index;
    logic        record_done;
    logic        payload_end;
    logic        end_status;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held_tag;
    logic [15:0] held_length;
    logic [15:0] bytes_left;
    logic [15:0] byte_position;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    phase:         PH_TAG,
    held_tag:      8'd0,
    held_length:   16'd0,
    bytes_left:    16'd0,
    byte_position: 16'd0
  };

endpackage

`default_nettype wire

// ===== rtl/tlv_record_parser.sv =====
// ----------------------------------------------------------------------------
// tlv_record_parser: tag-length-value record parser
// Classifies a payload byte stream into tag, length and data bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall, payload item (data_byte,
//                    payload_last). A transaction moves when valid is high
//                    and stall is low.
//   result channel : result_valid / result_stall, payload result, one
//                    result transaction for every item transaction, in order.
//   Each result is registered and presented in the cycle after its item is taken.
//   One byte per cycle while no waiting result is stalled; the parser state
//   update loop is made of 16-bit adds and compares.
//   Each byte is tagged with its kind, the record tag, the record length
//   once known and the data index. A 0xFF length byte announces a two-byte
//   big-endian length. The byte marked payload_last reports whether the
//   payload ended on a record boundary, and the parser then restarts at
//   a tag with all state cleared.
//   Reset (rst, synchronous): parser expects a tag, result register empty.
//   Stall: while result_stall holds a waiting result, item_stall is raised
//   in the same cycle; a taken result frees the register for a new byte
//   in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_record_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire tlvp_pkg::item_t item,
  output logic              result_valid,
  input  wire logic         result_stall,
  output tlvp_pkg::result_t result
);

  tlvp_pkg::state_t  state;
  tlvp_pkg::state_t  state_next;
  tlvp_pkg::result_t step_result;
  logic              accept;

  // result register full and not draining: hold the byte source off
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  tlvp_step u_step (
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (step_result)
  );

  // parser state advances only on an accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlvp_pkg::STATE_CLEAR;
    end else if (accept) begin
      state <= state_next;
    end
  end

  tlvp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (step_result),
    .stall     (result_stall),
    .valid     (result_valid),
    .data      (result)
  );

  // last data byte of a record sits at index length - 1
  a_done_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.record_done && result.byte_kind == tlvp_pkg::KIND_DATA
    |-> result.data_index == result.record_length - 16'd1)
    else $error("record end at wrong data index");

  // payload end always returns the parser to the tag phase
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && item.payload_last
    |=> state.phase == tlvp_pkg::PH_TAG && state.byte_position == 16'd0)
    else $error("parser did not restart after payload end");

  // truncation is only reported on the final byte
  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.end_status |-> result.payload_end && !result.record_done)
    else $error("end status outside payload end");

  // a tag byte has no length yet and never closes a record
  a_tag_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_kind == tlvp_pkg::KIND_TAG
    |-> result.record_length == 16'd0 && !result.record_done)
    else $error("tag byte with length or record end");

endmodule

`default_nettype wire

// ===== rtl/tlvp_step.sv =====
// ----------------------------------------------------------------------------
// tlvp_step: per-byte parse step
// Classifies one byte against the current state, forms its result and the
// next parser state.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvp_step (
  input  wire tlvp_pkg::state_t state,
  input  wire tlvp_pkg::item_t  item,
  output tlvp_pkg::state_t  state_next,
  output tlvp_pkg::result_t result
);

  logic [7:0]      b;
  logic [15:0]     len;
  logic [15:0]     left_dec;
  logic            done;
  tlvp_pkg::kind_t kind;
  logic [15:0]     rlen;
  logic [15:0]     didx;
  tlvp_pkg::state_t upd;

  assign b        = item.data_byte;
  assign left_dec = state.bytes_left - 16'd1;

  always_comb begin
    upd  = state;
    done = 1'b0;
    kind = tlvp_pkg::KIND_TAG;
    rlen = 16'd0;
    didx = 16'd0;
    len  = 16'd0;
    case (state.phase)
      tlvp_pkg::PH_LEN: begin
        kind = tlvp_pkg::KIND_LEN;
        if (b == tlvp_pkg::EXT_MARKER) begin
          upd.phase = tlvp_pkg::PH_EXTHI;
        end else begin
          len  = {8'd0, b};
          rlen = len;
        end
      end
      tlvp_pkg::PH_EXTHI: begin
        kind            = tlvp_pkg::KIND_EXTHI;
        upd.held_length = {b, 8'd0};
        upd.phase       = tlvp_pkg::PH_EXTLO;
      end
      tlvp_pkg::PH_EXTLO: begin
        kind = tlvp_pkg::KIND_EXTLO;
        len  = state.held_length | {8'd0, b};
        rlen = len;
      end
      tlvp_pkg::PH_DATA: begin
        kind              = tlvp_pkg::KIND_DATA;
        rlen              = state.held_length;
        didx              = state.byte_position;
        upd.byte_position = state.byte_position + 16'd1;
        upd.bytes_left    = left_dec;
        if (left_dec == 16'd0) begin
          done      = 1'b1;
          upd.phase = tlvp_pkg::PH_TAG;
        end
      end
      default: begin
        // unused phase codes act as the tag phase
        kind              = tlvp_pkg::KIND_TAG;
        upd.held_tag      = b;
        upd.held_length   = 16'd0;
        upd.bytes_left    = 16'd0;
        upd.byte_position = 16'd0;
        upd.phase         = tlvp_pkg::PH_LEN;
      end
    endcase

    // known length: start data phase, zero length closes the record here
    if ((state.phase == tlvp_pkg::PH_LEN && b != tlvp_pkg::EXT_MARKER) ||
        state.phase == tlvp_pkg::PH_EXTLO) begin
      upd.held_length   = len;
      upd.bytes_left    = len;
      upd.byte_position = 16'd0;
      if (len == 16'd0) begin
        done      = 1'b1;
        upd.phase = tlvp_pkg::PH_TAG;
      end else begin
        upd.phase = tlvp_pkg::PH_DATA;
      end
    end
  end

  assign state_next = item.payload_last ? tlvp_pkg::STATE_CLEAR : upd;

  assign result.echo_byte     = b;
  assign result.byte_kind     = kind;
  assign result.record_tag    = upd.held_tag;
  assign result.record_length = rlen;
  assign result.data_index    = didx;
  assign result.record_done   = done;
  assign result.payload_end   = item.payload_last;
  assign result.end_status    = item.payload_last & ~done;

endmodule

`default_nettype wire

// ===== rtl/tlvp_out_reg.sv =====
// ----------------------------------------------------------------------------
// tlvp_out_reg: result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvp_out_reg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire tlvp_pkg::result_t load_data,
  input  wire logic         stall,
  output logic              valid,
  output tlvp_pkg::result_t data
);

  logic valid_next;

  assign valid_next = load | (valid & stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tlv_record_parser_tb.sv =====
// ----------------------------------------------------------------------------
// tlv_record_parser_tb: self-checking bench for the TLV record parser
// Feeds directed and random payloads (well-formed, cut short and noise),
// predicts every result transaction in a scoreboard and compares field by
// field, under four phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_record_parser_tb;

  // cycles without any accepted transaction before the run is called hung
  localparam int unsigned QUIET_LIMIT = 4000;
  // random byte target per idling phase
  localparam int unsigned PHASE_BYTES = 312;

  // ---------------------------------------------------------------------------
  // Scoreboard: tracks the parser state on its own and holds the results that
  // are still owed by the block, oldest first.
  // ---------------------------------------------------------------------------
  class parse_tracker;
    tlvp_pkg::phase_t  phase;
    logic [7:0]        tag;
    logic [15:0]       rec_len;
    logic [15:0]       left;
    logic [15:0]       pos;
    tlvp_pkg::result_t owed[$];
    int unsigned       errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase   = tlvp_pkg::PH_TAG;
      tag     = 8'd0;
      rec_len = 16'd0;
      left    = 16'd0;
      pos     = 16'd0;
    endfunction

    // known length: enter the data phase, or close the record right away
    function bit open_data(logic [15:0] n);
      rec_len = n;
      left    = n;
      pos     = 16'd0;
      if (n == 16'd0) begin
        phase = tlvp_pkg::PH_TAG;
        return 1'b1;
      end
      phase = tlvp_pkg::PH_DATA;
      return 1'b0;
    endfunction

    // accepted input byte: work out the result it must produce
    function void take_byte(tlvp_pkg::item_t it);
      tlvp_pkg::result_t r;
      logic              done;
      logic [15:0]       ext_len;
      r    = '0;
      done = 1'b0;
      r.echo_byte = it.data_byte;
      case (phase)
        tlvp_pkg::PH_LEN: begin
          r.byte_kind = tlvp_pkg::KIND_LEN;
          if (it.data_byte == tlvp_pkg::EXT_MARKER) begin
            phase = tlvp_pkg::PH_EXTHI;
          end else begin
            done = open_data({8'h00, it.data_byte});
            r.record_length = {8'h00, it.data_byte};
          end
        end
        tlvp_pkg::PH_EXTHI: begin
          r.byte_kind = tlvp_pkg::KIND_EXTHI;
          rec_len = {it.data_byte, 8'h00};
          phase = tlvp_pkg::PH_EXTLO;
        end
        tlvp_pkg::PH_EXTLO: begin
          r.byte_kind = tlvp_pkg::KIND_EXTLO;
          ext_len = rec_len | {8'h00, it.data_byte};
          done = open_data(ext_len);
          r.record_length = ext_len;
        end
        tlvp_pkg::PH_DATA: begin
          r.byte_kind = tlvp_pkg::KIND_DATA;
          r.record_length = rec_len;
          r.data_index = pos;
          pos  = pos + 16'd1;
          left = left - 16'd1;
          if (left == 16'd0) begin
            done = 1'b1;
            phase = tlvp_pkg::PH_TAG;
          end
        end
        default: begin
          r.byte_kind = tlvp_pkg::KIND_TAG;
          tag     = it.data_byte;
          rec_len = 16'd0;
          left    = 16'd0;
          pos     = 16'd0;
          phase   = tlvp_pkg::PH_LEN;
        end
      endcase
      r.record_tag  = tag;
      r.record_done = done;
      r.payload_end = it.payload_last;
      r.end_status  = it.payload_last && !done;
      if (it.payload_last) clear();
      owed.push_back(r);
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tlvp_pkg::result_t got);
      tlvp_pkg::result_t want;
      if (owed.size() == 0) begin
        $error("result transaction with nothing expected: %h", got);
        errors++;
        return;
      end
      want = owed.pop_front();
      cmp_field("echo_byte",     16'(want.echo_byte),     16'(got.echo_byte));
      cmp_field("byte_kind",     16'(want.byte_kind),     16'(got.byte_kind));
      cmp_field("record_tag",    16'(want.record_tag),    16'(got.record_tag));
      cmp_field("record_length", want.record_length,      got.record_length);
      cmp_field("data_index",    want.data_index,         got.data_index);
      cmp_field("record_done",   16'(want.record_done),   16'(got.record_done));
      cmp_field("payload_end",   16'(want.payload_end),   16'(got.payload_end));
      cmp_field("end_status",    16'(want.end_status),    16'(got.end_status));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block
  // ---------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  tlvp_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  tlvp_pkg::result_t result;

  always #6 clk = ~clk;

  tlv_record_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  parse_tracker book = new();

  int unsigned send_idle_pct = 0;   // chance per cycle the sender holds off
  int unsigned recv_stall_pct = 0;  // chance per cycle the receiver stalls
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Receiver side: takes results, checks them, drives random stalls, and
  // keeps the watchdog. Values read here are the ones from before the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (result_valid && !result_stall) book.check_result(result);
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no transaction for %0d cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // One byte transaction. Called at a rising edge; returns at the edge that
  // accepted it, so the next call can keep valid high without a dip.
  task automatic send_item(input tlvp_pkg::item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    book.take_byte(it);
    bytes_sent++;
  endtask

  // payload_last goes on the final byte only
  task automatic send_payload(input logic [7:0] pl[$]);
    tlvp_pkg::item_t it;
    for (int i = 0; i < pl.size(); i++) begin
      it.data_byte = pl[i];
      it.payload_last = (i == pl.size() - 1);
      send_item(it);
    end
  endtask

  // Random payload: mostly well-formed records with random content, some cut
  // short at a random byte, some pure noise.
  task automatic build_payload(output logic [7:0] pl[$]);
    int unsigned roll, form, nrec, len, ndata;
    bit          cut_off;
    pl = {};
    cut_off = 1'b0;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 12)) pl.push_back(8'($urandom_range(0, 255)));
    end else begin
      nrec = $urandom_range(1, 4);
      repeat (nrec) begin
        if (!cut_off) begin
          pl.push_back(8'($urandom_range(0, 255)));
          form = $urandom_range(0, 99);
          if (form < 62) begin
            len = $urandom_range(0, 8);
          end else if (form < 64) begin
            len = $urandom_range(200, 254);
          end else if (form < 90) begin
            len = $urandom_range(0, 12);
          end else begin
            len = $urandom_range(256, 65535);
          end
          if (form < 64) begin
            pl.push_back(8'(len));
          end else begin
            pl.push_back(tlvp_pkg::EXT_MARKER);
            pl.push_back(8'(len >> 8));
            pl.push_back(8'(len));
          end
          // huge records are never finished: a few data bytes, then the end
          ndata = (len > 255) ? $urandom_range(0, 6) : len;
          repeat (ndata) pl.push_back(8'($urandom_range(0, 255)));
          if (len > 255) cut_off = 1'b1;
        end
      end
      // broken payload: stop at a random byte inside
      if (roll < 22 && pl.size() > 1) pl = pl[0:$urandom_range(0, pl.size() - 2)];
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] pl[$];

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed payloads, no idling.
    // tag on the last byte: truncated
    send_payload('{8'h00});
    // zero length closes the record on the length byte, payload complete
    send_payload('{8'hFF, 8'h00});
    // short record, data extremes
    send_payload('{8'h5A, 8'h02, 8'hFF, 8'h00});
    // extended length of zero closes on the low length byte
    send_payload('{8'h01, tlvp_pkg::EXT_MARKER, 8'h00, 8'h00});
    // extended length of three
    send_payload('{8'hA5, tlvp_pkg::EXT_MARKER, 8'h00, 8'h03, 8'h11, 8'h80, 8'h7F});
    // maximum length, payload ends inside the data: truncated
    send_payload('{8'h7E, tlvp_pkg::EXT_MARKER, 8'hFF, 8'hFF, 8'h12});
    // payload ends on the marker: truncated
    send_payload('{8'h33, tlvp_pkg::EXT_MARKER});

    // Random payloads in four idling phases.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
      endcase
      for (int unsigned mark = bytes_sent; bytes_sent < mark + PHASE_BYTES; ) begin
        build_payload(pl);
        send_payload(pl);
      end
    end
    item_valid <= 1'b0;

    // drain, then let the pipeline run idle before the end
    while (book.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (book.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
